FILE: hw/rtl/bra_pkg.sv
// Package with types, constants and helpers shared by the bitmap run allocator.
`timescale 1ns / 1ps
`default_nettype none
package bra_pkg;

   localparam int BITS_PER_WORD = 32;
   localparam int BIT_W         = 5;
   localparam int COUNT_W       = 6;
   localparam int SLOT_W        = 9;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACCESS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     found;
      logic [BIT_W-1:0]         pos;
      logic [BITS_PER_WORD-1:0] mask;
   } run_hit_type;

   // Mask of n low ones, saturating at a full word.
   function automatic logic [BITS_PER_WORD-1:0] run_mask(input logic [COUNT_W-1:0] n);
      logic [BITS_PER_WORD-1:0] m;
      if (n >= COUNT_W'(BITS_PER_WORD)) begin
         m = '1;
      end else begin
         m = (BITS_PER_WORD'(1) << n[BIT_W-1:0]) - BITS_PER_WORD'(1);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bra_run_find.sv
// Finds the lowest position in one word where a run of clear bits fits.
`timescale 1ns / 1ps
`default_nettype none
module bra_run_find (
   input  wire logic [bra_pkg::BITS_PER_WORD-1:0] word_i,
   input  wire logic [bra_pkg::BITS_PER_WORD-1:0] run_i,
   input  wire logic [bra_pkg::COUNT_W-1:0]       count_i,
   output bra_pkg::run_hit_type                   hit_o
);
   import bra_pkg::*;

   always_comb begin
      logic [BITS_PER_WORD-1:0] cand;
      hit_o = '0;
      cand  = '0;
      for (int b = BITS_PER_WORD - 1; b >= 0; b--) begin
         cand = run_i << b;
         if (((word_i & cand) == '0) &&
             ((7'(b) + {1'b0, count_i}) <= 7'(BITS_PER_WORD))) begin
            hit_o.found = 1'b1;
            hit_o.pos   = BIT_W'(b);
            hit_o.mask  = cand;
         end
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/bra_map.sv
// Occupancy bitmap memory with per-word valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bra_map #(
   parameter int WORDS = 16,
   parameter int AW    = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              clr,
   input  wire logic                              wr_en,
   input  wire logic [AW-1:0]                     wr_addr,
   input  wire logic [bra_pkg::BITS_PER_WORD-1:0] wr_data,
   input  wire logic [AW-1:0]                     rd_addr,
   output logic      [bra_pkg::BITS_PER_WORD-1:0] rd_data
);
   import bra_pkg::*;

   logic [BITS_PER_WORD-1:0] mem_ff [WORDS];
   logic [WORDS-1:0]         vld_ff;
   logic [BITS_PER_WORD-1:0] rd_data_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (clr) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/bitmap_run_allocator_top.sv
// Top level of the bitmap run allocator: sequencer, result register and map.
// rsp_valid rises when an item finishes; an allocation scans one map word per cycle,
// free and query pass through an access state, clear and a rejected count go to done.
// req_stall falls in the same cycle as the result moves into the output register,
// so one item is in flight at a time; a stalled output delays the next acceptance.
// Synchronous reset empties the map, sets the scan start to word zero and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_run_allocator_top #(
   parameter int WORDS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [bra_pkg::COUNT_W-1:0] req_count,
   input  wire logic [bra_pkg::SLOT_W-1:0]  req_slot,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_ok,
   output logic      [bra_pkg::SLOT_W-1:0]  rsp_slot_out,
   output logic                             rsp_used
);
   import bra_pkg::*;

   localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CAPACITY = WORDS * BITS_PER_WORD;

   state_type                state_ff, state_in;
   opcode_type               op_ff, op_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic                     in_range_ff, in_range_in;
   logic [BITS_PER_WORD-1:0] run_ff, run_in;
   logic [AW-1:0]            word_ff, word_in;
   logic [AW-1:0]            cnt_ff, cnt_in;
   logic [AW-1:0]            last_word_ff, last_word_in;
   logic                     res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic                     res_used_ff, res_used_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic                     rsp_used_ff, rsp_used_in;

   logic                     accept;
   logic                     out_free;
   logic                     count_ok;
   logic                     last_try;
   opcode_type               req_op;
   logic [AW-1:0]            slot_word;
   logic [AW-1:0]            next_word;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [BITS_PER_WORD-1:0] wr_data;
   logic                     clr;
   logic [BITS_PER_WORD-1:0] map_rd_data;
   run_hit_type              hit;

   bra_map #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .clr     (clr),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (map_rd_data)
   );

   bra_run_find u_find (
      .word_i  (map_rd_data),
      .run_i   (run_ff),
      .count_i (count_ff),
      .hit_o   (hit)
   );

   assign req_op    = opcode_type'(req_opcode);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_ok  = (req_count != '0) && (req_count <= COUNT_W'(BITS_PER_WORD));
   assign slot_word = AW'(req_slot >> BIT_W);
   assign next_word = (word_ff == AW'(WORDS - 1)) ? '0 : word_ff + AW'(1);
   assign last_try  = (cnt_ff == AW'(WORDS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ALLOC:          state_in = count_ok ? ST_SCAN : ST_DONE;
                  OP_FREE, OP_QUERY: state_in = ST_ACCESS;
                  OP_CLEAR:          state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit.found || last_try) begin
               state_in = ST_DONE;
            end
         end
         ST_ACCESS: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      count_in     = count_ff;
      bit_in       = bit_ff;
      in_range_in  = in_range_ff;
      run_in       = run_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_word_in = last_word_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      res_used_in  = res_used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_used_in  = rsp_used_ff;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_data      = map_rd_data | hit.mask;
      clr          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_op == OP_ALLOC) ? last_word_ff : slot_word;
            if (accept) begin
               op_in       = req_op;
               count_in    = req_count;
               bit_in      = req_slot[BIT_W-1:0];
               in_range_in = (32'(req_slot) < 32'(CAPACITY));
               run_in      = run_mask(req_count);
               word_in     = rd_addr;
               cnt_in      = '0;
               res_ok_in   = !((req_op == OP_ALLOC) && !count_ok);
               res_slot_in = '0;
               res_used_in = 1'b0;
               if (req_op == OP_CLEAR) begin
                  clr          = 1'b1;
                  last_word_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (hit.found) begin
               wr_en        = 1'b1;
               last_word_in = word_ff;
               res_slot_in  = SLOT_W'({word_ff, hit.pos});
            end else if (last_try) begin
               res_ok_in = 1'b0;
            end else begin
               rd_addr = next_word;
               word_in = next_word;
               cnt_in  = cnt_ff + AW'(1);
            end
         end
         ST_ACCESS: begin
            if (op_ff == OP_FREE) begin
               wr_en   = in_range_ff;
               wr_data = map_rd_data & ~(run_ff << bit_ff);
            end else begin
               res_used_in = in_range_ff && map_rd_data[bit_ff];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_used_in  = res_used_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_word_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_word_ff <= last_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      count_ff    <= count_in;
      bit_ff      <= bit_in;
      in_range_ff <= in_range_in;
      run_ff      <= run_in;
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      res_used_ff <= res_used_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_used     = rsp_used_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("Result presented without a finished item.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= AW'(WORDS - 1)))
      else $error("Scan ran past the last word.");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_ok_ff) |-> (res_slot_ff == '0 && !res_used_ff))
      else $error("Failed allocation carries a slot or used bit.");

   a_grant_updates_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit.found) |=> (last_word_ff == $past(word_ff)))
      else $error("Granted word not recorded as scan start.");

endmodule
`default_nettype wire
